>>> src/indexed_ordered_list_engine_assert.svh
// assertion helpers for the ordered list engine
// the clock clk and the reset rst_n must be in scope where these are used
`ifndef INDEXED_ORDERED_LIST_ENGINE_ASSERT_SVH
`define INDEXED_ORDERED_LIST_ENGINE_ASSERT_SVH

// property checked every clock outside reset
`define IOLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every clock, reset included
`define IOLE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/iole_pkg.sv
package iole_pkg;

    // fixed field widths of the request and response items
    localparam int POS_BITS = 7;
    localparam int OUT_VAL_BITS = 32;

    // value returned by a read outside the list
    localparam logic [OUT_VAL_BITS-1:0] READ_MISS = 32'h7fff_ffff;

    typedef enum logic [2:0] {
        OP_INS_FIRST = 3'd0,
        OP_INS_LAST  = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_RM_FIRST  = 3'd3,
        OP_RM_LAST   = 3'd4,
        OP_RM_AT     = 3'd5,
        OP_SEARCH    = 3'd6,
        OP_READ      = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef struct packed {
        op_t                       req_type;
        logic [POS_BITS-1:0]       position;
        logic signed [31:0]        item_value;
    } req_t;

    typedef struct packed {
        status_t                   status;
        logic                      found;
        logic signed [31:0]        read_value;
        logic [POS_BITS-1:0]       entry_count;
    } rsp_t;

endpackage

>>> src/indexed_ordered_list_engine.sv
// Ordered list engine: an ordered list of up to CAPACITY signed values.
// Request channel (req_valid/req_ready/req) carries one operation item:
// insert first/last/at, remove first/last/at, search or read. Response
// channel (rsp_valid/rsp_ready/rsp) returns exactly one item per request
// with status, found flag, read value and the entry count afterwards.
// One request is worked on at a time; req_ready is low while it runs.
// All work goes through one list memory with one read and one write port
// and a single index counter; every request goes through exec, its own steps, done:
//   insert at p : a shift read and write per entry from p up, then put
//   remove at p : a shift read and write per entry after p
//   search      : a read and compare per entry compared     read : read, read done
//   refused requests (range, full, empty) go straight to done.
// The response sits in an output register; a new request is accepted
// while it waits only if it is taken in the same cycle, so a stalled
// receiver holds the block after the current result.
// Reset (rst_n low, asynchronous) empties the list at once; memory
// contents are not cleared and are read only after being written.
module indexed_ordered_list_engine #(
    parameter int CAPACITY = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  iole_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output iole_pkg::rsp_t rsp
);

    localparam int AW = $clog2(CAPACITY);

    logic                  seq_idle;
    logic                  seq_res_valid;
    iole_pkg::rsp_t        seq_res;
    logic                  start;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [VALUE_BITS-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [VALUE_BITS-1:0] ram_rdata;

    logic           rsp_valid_reg, rsp_valid_next;
    iole_pkg::rsp_t rsp_reg;

    // accept when idle and the output slot is free or draining
    assign req_ready = seq_idle && (!rsp_valid_reg || rsp_ready);
    assign start     = req_valid && req_ready;

    iole_seq #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .idle      (seq_idle),
        .res_valid (seq_res_valid),
        .res       (seq_res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    iole_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // output register valid
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (seq_res_valid)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (seq_res_valid)
        begin
            rsp_reg <= seq_res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> src/iole_ram.sv
module iole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/iole_seq.sv
module iole_seq #(
    parameter int CAPACITY = 64,
    parameter int VALUE_BITS = 32,
    localparam int CW = $clog2(CAPACITY + 1),
    localparam int AW = $clog2(CAPACITY)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  iole_pkg::req_t        req,
    output logic                  idle,
    output logic                  res_valid,
    output iole_pkg::rsp_t        res,
    output logic                  ram_we,
    output logic [AW-1:0]         ram_waddr,
    output logic [VALUE_BITS-1:0] ram_wdata,
    output logic [AW-1:0]         ram_raddr,
    input  logic [VALUE_BITS-1:0] ram_rdata
);

    localparam int PW = (CW > iole_pkg::POS_BITS) ? CW : iole_pkg::POS_BITS;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    typedef enum logic [9:0] {
        S_IDLE      = 10'b00_0000_0001,
        S_EXEC      = 10'b00_0000_0010,
        S_SHIFT_RD  = 10'b00_0000_0100,
        S_SHIFT_WR  = 10'b00_0000_1000,
        S_PUT       = 10'b00_0001_0000,
        S_SRCH_RD   = 10'b00_0010_0000,
        S_SRCH_CMP  = 10'b00_0100_0000,
        S_READ_RD   = 10'b00_1000_0000,
        S_READ_DONE = 10'b01_0000_0000,
        S_DONE      = 10'b10_0000_0000
    } state_t;

    state_t                            state_reg, state_next;
    logic [CW-1:0]                     count_reg, count_next;
    iole_pkg::op_t                     op_reg, op_next;
    logic [iole_pkg::POS_BITS-1:0]     pos_reg, pos_next;
    logic [VALUE_BITS-1:0]             val_reg, val_next;
    logic [CW-1:0]                     idx_reg, idx_next;
    logic [CW-1:0]                     at_reg, at_next;
    iole_pkg::status_t                 status_reg, status_next;
    logic                              found_reg, found_next;
    logic [iole_pkg::OUT_VAL_BITS-1:0] rdv_reg, rdv_next;

    logic          ins_op;
    logic [PW-1:0] pos_w;
    logic [PW-1:0] cnt_w;
    logic [PW-1:0] at_w;

    assign ins_op = op_reg inside {iole_pkg::OP_INS_FIRST, iole_pkg::OP_INS_LAST,
                                   iole_pkg::OP_INS_AT};
    assign pos_w = PW'(pos_reg);
    assign cnt_w = PW'(count_reg);

    // target position of the request
    always_comb
    begin
        case (op_reg)
            iole_pkg::OP_INS_FIRST: at_w = '0;
            iole_pkg::OP_INS_LAST:  at_w = cnt_w;
            iole_pkg::OP_RM_FIRST:  at_w = '0;
            iole_pkg::OP_RM_LAST:   at_w = cnt_w - PW'(1);
            default:                at_w = pos_w;
        endcase
    end

    // sequencer: at most one ram write and one index step per state
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        op_next     = op_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        idx_next    = idx_reg;
        at_next     = at_reg;
        status_next = status_reg;
        found_next  = found_reg;
        rdv_next    = rdv_reg;
        ram_we      = 1'b0;
        ram_waddr   = idx_reg[AW-1:0];
        ram_wdata   = ram_rdata;
        ram_raddr   = idx_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next     = req.req_type;
                    pos_next    = req.position;
                    val_next    = VALUE_BITS'(req.item_value);
                    status_next = iole_pkg::ST_OK;
                    found_next  = 1'b0;
                    rdv_next    = '0;
                    state_next  = S_EXEC;
                end
            end

            S_EXEC:
            begin
                case (op_reg)
                    iole_pkg::OP_INS_FIRST, iole_pkg::OP_INS_LAST, iole_pkg::OP_INS_AT:
                    begin
                        if (at_w > cnt_w)
                        begin
                            status_next = iole_pkg::ST_RANGE;
                            state_next  = S_DONE;
                        end
                        else if (count_reg == CAP_CNT)
                        begin
                            status_next = iole_pkg::ST_FULL;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            at_next  = CW'(at_w);
                            idx_next = count_reg;
                            state_next = (count_reg == CW'(at_w)) ? S_PUT : S_SHIFT_RD;
                        end
                    end
                    iole_pkg::OP_RM_FIRST, iole_pkg::OP_RM_LAST, iole_pkg::OP_RM_AT:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = iole_pkg::ST_EMPTY;
                            state_next  = S_DONE;
                        end
                        else if (at_w >= cnt_w)
                        begin
                            status_next = iole_pkg::ST_RANGE;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            at_next  = CW'(at_w);
                            idx_next = CW'(at_w);
                            if (CW'(at_w) + CW'(1) == count_reg)
                            begin
                                // last entry goes, nothing to move
                                count_next = count_reg - CW'(1);
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SHIFT_RD;
                            end
                        end
                    end
                    iole_pkg::OP_SEARCH:
                    begin
                        idx_next   = '0;
                        state_next = (count_reg == '0) ? S_DONE : S_SRCH_RD;
                    end
                    iole_pkg::OP_READ:
                    begin
                        if (pos_w < cnt_w)
                        begin
                            state_next = S_READ_RD;
                        end
                        else
                        begin
                            status_next = iole_pkg::ST_RANGE;
                            rdv_next    = iole_pkg::READ_MISS;
                            state_next  = S_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            // fetch the neighbor that moves into idx
            S_SHIFT_RD:
            begin
                ram_raddr  = ins_op ? idx_reg[AW-1:0] - AW'(1) : idx_reg[AW-1:0] + AW'(1);
                state_next = S_SHIFT_WR;
            end

            S_SHIFT_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg[AW-1:0];
                ram_wdata = ram_rdata;
                if (ins_op)
                begin
                    idx_next   = idx_reg - CW'(1);
                    state_next = (idx_reg - CW'(1) == at_reg) ? S_PUT : S_SHIFT_RD;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                    if (idx_reg + CW'(2) == count_reg)
                    begin
                        count_next = count_reg - CW'(1);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SHIFT_RD;
                    end
                end
            end

            // place the new value in the opened slot
            S_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = at_reg[AW-1:0];
                ram_wdata  = val_reg;
                count_next = count_reg + CW'(1);
                state_next = S_DONE;
            end

            S_SRCH_RD:
            begin
                state_next = S_SRCH_CMP;
            end

            // compare one entry per pass
            S_SRCH_CMP:
            begin
                if (ram_rdata == val_reg)
                begin
                    found_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = (idx_reg + CW'(1) == count_reg) ? S_DONE : S_SRCH_RD;
                end
            end

            S_READ_RD:
            begin
                ram_raddr  = AW'(pos_reg);
                state_next = S_READ_DONE;
            end

            S_READ_DONE:
            begin
                rdv_next   = iole_pkg::OUT_VAL_BITS'(ram_rdata);
                state_next = S_DONE;
            end

            S_DONE:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        idx_reg    <= idx_next;
        at_reg     <= at_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        rdv_reg    <= rdv_next;
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    always_comb
    begin
        res.status      = status_reg;
        res.found       = found_reg;
        res.read_value  = rdv_reg;
        res.entry_count = iole_pkg::POS_BITS'(count_reg);
    end

endmodule

>>> src/iole_checker.sv
`include "indexed_ordered_list_engine_assert.svh"

module iole_checker #(
    parameter int CAPACITY = 64
) (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input iole_pkg::rsp_t rsp
);

    localparam logic [iole_pkg::POS_BITS-1:0] CAP_CNT = iole_pkg::POS_BITS'(CAPACITY);

    logic rsp_stall;
    logic req_take;
    logic rsp_full;
    logic cnt_full;

    // handshake and status terms
    assign rsp_stall = rsp_valid && !rsp_ready;
    assign req_take  = req_valid && req_ready;
    assign rsp_full  = rsp_valid && (rsp.status == iole_pkg::ST_FULL);
    assign cnt_full  = (rsp.entry_count == CAP_CNT);

    // a waiting item holds until taken
    `IOLE_ASSERT(a_rsp_hold, rsp_stall |=> (rsp_valid && $stable(rsp)), "response item changed")

    // no new request while the result waits on a stalled receiver
    `IOLE_ASSERT_ALWAYS(a_no_accept_stalled, rsp_stall |-> !req_ready, "accept while stalled")

    // one request at a time
    `IOLE_ASSERT(a_busy_after_accept, req_take |=> !req_ready, "ready high after an accept")

    // full status only with a full list
    `IOLE_ASSERT(a_full_count, rsp_full |-> cnt_full, "full status with list not full")

endmodule

bind indexed_ordered_list_engine iole_checker #(.CAPACITY(CAPACITY)) u_iole_checker (.*);
